@@ rtl/fa_pkg.sv @@
// Frame allocator package: field widths, operation codes, frame state word.
// No dependencies; imported by every module of the allocator.
package fa_pkg;

   localparam int FUNC_W         = 2;
   localparam int FRAME_W        = 8;
   localparam int CNT_W          = 9;
   localparam int FRAME_LIMIT    = 256;
   localparam int MAX_FRAMES_DEF = 256;

   localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 9'd256;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ACCESS  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   typedef struct packed {
      logic alloc;
      logic used;
      logic modified;
   } frame_word_type;

   localparam frame_word_type GRANT_WORD = '{alloc: 1'b1, used: 1'b1, modified: 1'b0};

   typedef struct packed {
      logic hit;
      logic last;
   } step_flags_type;

endpackage

@@ rtl/fa_store.sv @@
// Frame state store: one word per frame, registered read with write bypass.
// Per-entry valid bits make unwritten entries read as a free frame. Uses fa_pkg.
module fa_store #(
   parameter int DEPTH = fa_pkg::MAX_FRAMES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output fa_pkg::frame_word_type     rd_word,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  fa_pkg::frame_word_type     wr_word
);
   import fa_pkg::*;

   frame_word_type mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   frame_word_type   rd_word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_word_ff <= wr_word;
      end else if (valid_ff[rd_addr]) begin
         rd_word_ff <= mem_ff[rd_addr];
      end else begin
         rd_word_ff <= '0;
      end
   end

   assign rd_word = rd_word_ff;

endmodule

@@ rtl/fa_step.sv @@
// Shared step unit: wrapped index advance, free-frame or unused-frame test and clock-sweep update.
// Used by the scan and by the sweep of the sequencer. Uses fa_pkg.
module fa_step #(
   parameter int DEPTH = fa_pkg::MAX_FRAMES_DEF
) (
   input  logic                       sweep,
   input  logic [$clog2(DEPTH)-1:0]   idx,
   input  logic [fa_pkg::CNT_W-1:0]   n_cnt,
   input  fa_pkg::frame_word_type     word,
   output logic [$clog2(DEPTH)-1:0]   next_idx,
   output fa_pkg::frame_word_type     new_word,
   output fa_pkg::step_flags_type     flags
);
   import fa_pkg::*;

   localparam int IW = $clog2(DEPTH);

   logic [CNT_W-1:0] inc;

   always_comb begin
      inc        = CNT_W'(idx) + CNT_W'(1);
      flags.last = (inc >= n_cnt);
      next_idx   = flags.last ? '0 : inc[IW-1:0];
      flags.hit  = sweep ? !word.used : !word.alloc;
      new_word   = word;
      if (word.used && word.modified) begin
         new_word.modified = 1'b0;
      end else begin
         new_word.used = 1'b0;
      end
   end

endmodule

@@ rtl/frame_allocator_modified_clock.sv @@
// Frame allocator with a modified-bit clock. A result word appears on the rsp_ ports
// for exactly one cycle with rsp_valid and cannot be held off. Release, out-of-range and
// unused codes answer in the cycle after start, access after a read in ST_ACC. Allocate checks
// one frame per cycle from frame zero; with none free the sweep follows, one frame per cycle,
// for the n managed frames. The rate is set by the one read per cycle of the frame state store.
// busy is high while an access or allocate is in work; no reset clearing pass is needed.
module frame_allocator_modified_clock #(
   parameter int MAX_FRAMES = fa_pkg::MAX_FRAMES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [fa_pkg::FUNC_W-1:0]  req_func,
   input  logic [fa_pkg::FRAME_W-1:0] req_frame,
   input  logic                       req_write,
   output logic                       rsp_valid,
   output logic [fa_pkg::FRAME_W-1:0] rsp_frame_out,
   output logic                       rsp_evicted,
   output logic                       rsp_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fa_pkg::CNT_W-1:0]   csr_data
);
   import fa_pkg::*;

   localparam int DEPTH = (MAX_FRAMES < FRAME_LIMIT) ? MAX_FRAMES : FRAME_LIMIT;
   localparam int IW    = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ACC   = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_SWEEP = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      hand_ff, hand_in;
   logic               wr_ff, wr_in;
   logic [CNT_W-1:0]   fc_ff, fc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic               rsp_ev_ff, rsp_ev_in;
   logic               rsp_st_ff, rsp_st_in;

   logic [CNT_W-1:0]   n_cnt;
   logic [IW-1:0]      sweep_start;
   logic               out_of_range;

   logic [IW-1:0]      rd_addr;
   frame_word_type     rd_word;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   frame_word_type     wr_word;

   logic [IW-1:0]      step_next;
   frame_word_type     step_word;
   step_flags_type     step_flags;

   fa_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_word (rd_word),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_word (wr_word)
   );

   fa_step #(.DEPTH(DEPTH)) u_step (
      .sweep    (state_ff == ST_SWEEP),
      .idx      (idx_ff),
      .n_cnt    (n_cnt),
      .word     (rd_word),
      .next_idx (step_next),
      .new_word (step_word),
      .flags    (step_flags)
   );

   always_comb begin
      if (fc_ff == '0) begin
         n_cnt = CNT_W'(1);
      end else if (fc_ff > DEPTH_CNT) begin
         n_cnt = DEPTH_CNT;
      end else begin
         n_cnt = fc_ff;
      end
      sweep_start  = (CNT_W'(hand_ff) < n_cnt) ? hand_ff : '0;
      out_of_range = (CNT_W'(req_frame) >= n_cnt);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      hand_in      = hand_ff;
      wr_in        = wr_ff;
      fc_in        = csr_valid ? csr_data : fc_ff;
      rsp_valid_in = 1'b0;
      rsp_frame_in = rsp_frame_ff;
      rsp_ev_in    = 1'b0;
      rsp_st_in    = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_word      = GRANT_WORD;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_frame_in = req_frame;
               wr_in        = req_write;
               if (req_func == FUNC_ALLOC) begin
                  idx_in   = '0;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end else if ((req_func == FUNC_ACCESS) || (req_func == FUNC_RELEASE)) begin
                  if (out_of_range) begin
                     rsp_valid_in = 1'b1;
                     rsp_st_in    = 1'b1;
                  end else if (req_func == FUNC_ACCESS) begin
                     idx_in   = req_frame[IW-1:0];
                     rd_addr  = req_frame[IW-1:0];
                     state_in = ST_ACC;
                  end else begin
                     wr_en        = 1'b1;
                     wr_addr      = req_frame[IW-1:0];
                     wr_word      = '0;
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_ACC: begin
            if (rd_word.alloc) begin
               wr_en   = 1'b1;
               wr_word = '{alloc: 1'b1, used: 1'b1, modified: rd_word.modified | wr_ff};
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            if (step_flags.hit) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_frame_in = FRAME_W'(idx_ff);
               state_in     = ST_IDLE;
            end else if (step_flags.last) begin
               idx_in   = sweep_start;
               rd_addr  = sweep_start;
               state_in = ST_SWEEP;
            end else begin
               idx_in  = step_next;
               rd_addr = step_next;
            end
         end
         ST_SWEEP: begin
            wr_en = 1'b1;
            if (step_flags.hit) begin
               hand_in      = step_next;
               rsp_valid_in = 1'b1;
               rsp_frame_in = FRAME_W'(idx_ff);
               rsp_ev_in    = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               wr_word = step_word;
               idx_in  = step_next;
               rd_addr = step_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hand_ff      <= '0;
         fc_ff        <= FRAME_COUNT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      wr_ff        <= wr_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_st_ff    <= rsp_st_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frame_out = rsp_frame_ff;
   assign rsp_evicted   = rsp_ev_ff;
   assign rsp_status    = rsp_st_ff;

endmodule

@@ tb/sv/frame_allocator_modified_clock_test.sv @@
// Self-checking bench for frame_allocator_modified_clock: directed words, then random phases
// at several frame counts, checked against a built-in clock-sweep predictor.
// Depends on rtl/fa_pkg.sv, rtl/frame_allocator_modified_clock.sv, rtl/fa_store.sv and rtl/fa_step.sv.
module frame_allocator_modified_clock_test;
   import fa_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int DRAIN_CYCLES = 3 * FRAME_LIMIT + 8;
   localparam int PHASES = 10;
   localparam int FRAME_CAP = (MAX_FRAMES_DEF < FRAME_LIMIT) ? MAX_FRAMES_DEF : FRAME_LIMIT;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [FRAME_W-1:0] frame;
      logic               write;
   } fa_request_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_out;
      logic               evicted;
      logic               status;
   } fa_answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [FUNC_W-1:0]  req_func = '0;
   logic [FRAME_W-1:0] req_frame = '0;
   logic               req_write = 1'b0;
   logic               rsp_valid;
   logic [FRAME_W-1:0] rsp_frame_out;
   logic               rsp_evicted;
   logic               rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CNT_W-1:0]   csr_data = '0;

   fa_request_type pending_requests[$];
   fa_answer_type  expected_answers[$];
   logic           took = 1'b0;
   int unsigned    sender_idle_pct = 16;
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;

   // predictor state
   bit               alloc_map [FRAME_LIMIT];
   bit               used_map  [FRAME_LIMIT];
   bit               dirty_map [FRAME_LIMIT];
   int unsigned      hand_pos;
   logic [CNT_W-1:0] frame_count_reg;

   frame_allocator_modified_clock dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_frame    (req_frame),
      .req_write    (req_write),
      .rsp_valid    (rsp_valid),
      .rsp_frame_out(rsp_frame_out),
      .rsp_evicted  (rsp_evicted),
      .rsp_status   (rsp_status),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned managed_frames();
      int unsigned n;
      n = frame_count_reg;
      if (n == 0) n = 1;
      if (n > FRAME_CAP) n = FRAME_CAP;
      return n;
   endfunction

   function automatic fa_answer_type predict_answer(fa_request_type r);
      fa_answer_type a;
      int unsigned   n, i, j, steps, slot;
      bit            found, hit;
      n = managed_frames();
      a.frame_out = r.frame;
      a.evicted = 1'b0;
      a.status = 1'b0;
      case (r.func)
         FUNC_ALLOC: begin
            found = 1'b0;
            slot = 0;
            for (i = 0; i < n && !found; i++) begin
               if (!alloc_map[i]) begin
                  found = 1'b1;
                  slot = i;
               end
            end
            if (!found) begin
               // second-chance sweep: dirty loses dirty, used loses used, else victim
               j = (hand_pos < n) ? hand_pos : 0;
               hit = 1'b0;
               steps = 0;
               while (!hit && steps < 2 * n + 1) begin
                  if (used_map[j] && dirty_map[j]) dirty_map[j] = 1'b0;
                  else if (used_map[j]) used_map[j] = 1'b0;
                  else hit = 1'b1;
                  if (!hit) j = (j + 1 < n) ? j + 1 : 0;
                  steps++;
               end
               hand_pos = (j + 1 < n) ? j + 1 : 0;
               slot = j;
               a.evicted = 1'b1;
            end
            alloc_map[slot] = 1'b1;
            used_map[slot] = 1'b1;
            dirty_map[slot] = 1'b0;
            a.frame_out = slot[FRAME_W-1:0];
         end
         FUNC_ACCESS, FUNC_RELEASE: begin
            if (r.frame >= n) begin
               a.status = 1'b1;
            end else if (r.func == FUNC_ACCESS) begin
               if (alloc_map[r.frame]) begin
                  used_map[r.frame] = 1'b1;
                  if (r.write) dirty_map[r.frame] = 1'b1;
               end
            end else begin
               alloc_map[r.frame] = 1'b0;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   // scoreboard: results first, then config and the newly accepted word
   always @(posedge clock) begin : answer_check
      fa_answer_type  want;
      fa_request_type r;
      int             i;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("*** FAILED ***");
         $finish;
      end else if (reset) begin
         for (i = 0; i < FRAME_LIMIT; i++) begin
            alloc_map[i] = 1'b0;
            used_map[i] = 1'b0;
            dirty_map[i] = 1'b0;
         end
         hand_pos = 0;
         frame_count_reg = FRAME_COUNT_RST;
         took <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected word, frame_out %0d evicted %0d status %0d",
                        $time, rsp_frame_out, rsp_evicted, rsp_status);
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               check_field("frame_out", want.frame_out, rsp_frame_out);
               check_field("evicted", want.evicted, rsp_evicted);
               check_field("status", want.status, rsp_status);
            end
         end
         if (csr_valid && csr_ready) frame_count_reg = csr_data;
         if (start && !busy) begin
            r.func = req_func;
            r.frame = req_frame;
            r.write = req_write;
            expected_answers.push_back(predict_answer(r));
         end
         took <= start && !busy;
      end
   end

   always @(negedge clock) begin : issue
      fa_request_type r;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            r = pending_requests.pop_front();
            req_func <= r.func;
            req_frame <= r.frame;
            req_write <= r.write;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic push_request(input logic [FUNC_W-1:0] func, input int unsigned frame,
                               input bit write);
      fa_request_type r;
      r.func = func;
      r.frame = frame[FRAME_W-1:0];
      r.write = write;
      pending_requests.push_back(r);
   endtask

   task automatic wait_quiet();
      while (pending_requests.size() != 0 || start || expected_answers.size() != 0 || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frame_count(input logic [CNT_W-1:0] value);
      bit done;
      wait_quiet();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         done = csr_ready;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(input int unsigned count, input int unsigned alloc_pct);
      int unsigned n, hi, k, pick;
      n = managed_frames();
      hi = (n < 255) ? n : 255;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(19);
         if ($urandom_range(99) < alloc_pct)
            push_request(FUNC_ALLOC, $urandom_range(255), 1'($urandom_range(1)));
         else if (pick >= 18)
            push_request(FUNC_SPARE, $urandom_range(255), 1'($urandom_range(1)));
         else
            push_request((pick < 12) ? FUNC_ACCESS : FUNC_RELEASE,
                         ($urandom_range(9) < 8) ? $urandom_range(hi) : $urandom_range(255),
                         1'($urandom_range(1)));
      end
   endtask

   initial begin : stimulus
      int unsigned phase_count [PHASES];
      int unsigned p, size, mix;
      phase_count = '{5, 1, 2, 256, 0, 17, 511, 3, 64, 8};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: free-frame grants, idle frames, spare code, range errors, sweeps
      push_request(FUNC_ALLOC, 255, 1'b1);
      push_request(FUNC_ACCESS, 0, 1'b1);
      push_request(FUNC_ACCESS, 255, 1'b1);
      push_request(FUNC_RELEASE, 255, 1'b0);
      push_request(FUNC_SPARE, 170, 1'b1);
      push_request(FUNC_ALLOC, 0, 1'b0);
      push_request(FUNC_RELEASE, 0, 1'b0);
      push_request(FUNC_ALLOC, 85, 1'b0);
      write_frame_count(9'd1);
      push_request(FUNC_ACCESS, 1, 1'b0);
      push_request(FUNC_RELEASE, 255, 1'b1);
      push_request(FUNC_ALLOC, 0, 1'b0);
      push_request(FUNC_ACCESS, 0, 1'b1);
      push_request(FUNC_ALLOC, 0, 1'b0);
      push_request(FUNC_ACCESS, 0, 1'b0);
      push_request(FUNC_ALLOC, 0, 1'b0);
      write_frame_count(9'd2);
      push_request(FUNC_ACCESS, 1, 1'b1);
      push_request(FUNC_ALLOC, 0, 1'b0);
      push_request(FUNC_ACCESS, 0, 1'b1);
      push_request(FUNC_ALLOC, 0, 1'b0);
      push_request(FUNC_ALLOC, 0, 1'b0);
      push_request(FUNC_RELEASE, 1, 1'b0);
      push_request(FUNC_ACCESS, 2, 1'b1);

      for (p = 0; p < PHASES; p++) begin
         write_frame_count(phase_count[p][CNT_W-1:0]);
         sender_idle_pct = (p < 4) ? 16 : (p < 7) ? 73 : 0;
         size = (phase_count[p] == 256) ? 300 : 90;
         mix = (phase_count[p] == 256) ? 90 : 40;
         queue_random(size / 2, mix);
         wait_quiet();
         queue_random(size - size / 2, mix);
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
